/* design/time_of_day_arithmetic_unit_macros.svh */
// ----------------------------------------------------------------------------
// time of day arithmetic unit assertion macros
// shared property forms for the concurrent checks of the unit
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_ARITHMETIC_UNIT_MACROS_SVH
`define TIME_OF_DAY_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define TODAU_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
	else $error(msg);

// next-cycle implication
`define TODAU_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
	else $error(msg);

`endif

/* design/todau_pkg.sv */
// ----------------------------------------------------------------------------
// todau_pkg
// widths, operation codes, constants and stage types of the time unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package todau_pkg;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINSEC_W = 6;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned SECS_W   = 17;
	localparam int unsigned REM_W    = 12;

	localparam logic [OP_W-1:0] OP_FROM_SECONDS = 3'd0;
	localparam logic [OP_W-1:0] OP_TO_SECONDS   = 3'd1;
	localparam logic [OP_W-1:0] OP_NEXT         = 3'd2;
	localparam logic [OP_W-1:0] OP_PREV         = 3'd3;
	localparam logic [OP_W-1:0] OP_ADD          = 3'd4;
	localparam logic [OP_W-1:0] OP_SUBTRACT     = 3'd5;
	localparam logic [OP_W-1:0] OP_DURATION     = 3'd6;
	localparam logic [OP_W-1:0] OP_COMPARE      = 3'd7;

	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned MAX_HOUR      = 23;
	localparam int unsigned MAX_MINSEC    = 59;

	// count / 86400 = ((count >> 7) * recip) >> 35, exact over 32 bits
	localparam int unsigned DAY_PRE     = 7;
	localparam int unsigned DAY_RECIP   = 50903317;
	localparam int unsigned DAY_RECIP_W = 26;
	localparam int unsigned DAY_SHIFT   = 35;
	localparam int unsigned DAY_Q_W     = 16;

	// t / 3600 = ((t >> 4) * recip) >> 20, exact below one day
	localparam int unsigned HOUR_PRE     = 4;
	localparam int unsigned HOUR_RECIP   = 4661;
	localparam int unsigned HOUR_RECIP_W = 13;
	localparam int unsigned HOUR_SHIFT   = 20;

	// r / 60 = ((r >> 2) * recip) >> 14, exact below one hour
	localparam int unsigned MIN_PRE     = 2;
	localparam int unsigned MIN_RECIP   = 1093;
	localparam int unsigned MIN_RECIP_W = 11;
	localparam int unsigned MIN_SHIFT   = 14;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [HOUR_W-1:0]   hour_a;
		logic [MINSEC_W-1:0] minute_a;
		logic [MINSEC_W-1:0] second_a;
		logic [HOUR_W-1:0]   hour_b;
		logic [MINSEC_W-1:0] minute_b;
		logic [MINSEC_W-1:0] second_b;
		logic [COUNT_W-1:0]  count_seconds;
	} todau_req_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic              err;
		logic [SECS_W-1:0] ta;
		logic [SECS_W-1:0] tb;
		logic [SECS_W-1:0] cnt_mod;
	} todau_secs_t;

	typedef struct packed {
		logic [SECS_W-1:0] total;
		logic              eq;
		logic              lt;
		logic              gt;
		logic              err;
	} todau_side_t;

	typedef struct packed {
		logic [SECS_W-1:0] t;
		todau_side_t       side;
	} todau_mid_t;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINSEC_W-1:0] minute;
		logic [MINSEC_W-1:0] second;
		todau_side_t         side;
	} todau_res_t;

	function automatic logic time_ok(logic [HOUR_W-1:0] h, logic [MINSEC_W-1:0] m,
			logic [MINSEC_W-1:0] s);
		return (h <= HOUR_W'(MAX_HOUR)) && (m <= MINSEC_W'(MAX_MINSEC))
			&& (s <= MINSEC_W'(MAX_MINSEC));
	endfunction

	function automatic logic [SECS_W-1:0] to_secs(logic [HOUR_W-1:0] h,
			logic [MINSEC_W-1:0] m, logic [MINSEC_W-1:0] s);
		return SECS_W'(h) * SECS_W'(SECS_PER_HOUR) + SECS_W'(m) * SECS_W'(SECS_PER_MIN)
			+ SECS_W'(s);
	endfunction

endpackage

/* design/todau_in_if.sv */
// ----------------------------------------------------------------------------
// todau_in_if
// request channel: operation, two times and a seconds count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface todau_in_if;
	logic                              valid;
	logic                              ready;
	logic [todau_pkg::OP_W-1:0]        operation;
	logic [todau_pkg::HOUR_W-1:0]      hour_a;
	logic [todau_pkg::MINSEC_W-1:0]    minute_a;
	logic [todau_pkg::MINSEC_W-1:0]    second_a;
	logic [todau_pkg::HOUR_W-1:0]      hour_b;
	logic [todau_pkg::MINSEC_W-1:0]    minute_b;
	logic [todau_pkg::MINSEC_W-1:0]    second_b;
	logic [todau_pkg::COUNT_W-1:0]     count_seconds;

	modport source (
		output valid, operation, hour_a, minute_a, second_a,
		output hour_b, minute_b, second_b, count_seconds,
		input  ready
	);
	modport sink (
		input  valid, operation, hour_a, minute_a, second_a,
		input  hour_b, minute_b, second_b, count_seconds,
		output ready
	);
endinterface

/* design/todau_out_if.sv */
// ----------------------------------------------------------------------------
// todau_out_if
// result channel: time, seconds count, compare flags and error flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface todau_out_if;
	logic                              valid;
	logic                              ready;
	logic [todau_pkg::HOUR_W-1:0]      hour_out;
	logic [todau_pkg::MINSEC_W-1:0]    minute_out;
	logic [todau_pkg::MINSEC_W-1:0]    second_out;
	logic [todau_pkg::SECS_W-1:0]      total_seconds;
	logic                              is_equal;
	logic                              is_less;
	logic                              is_greater;
	logic                              operand_error;

	modport source (
		output valid, hour_out, minute_out, second_out, total_seconds,
		output is_equal, is_less, is_greater, operand_error,
		input  ready
	);
	modport sink (
		input  valid, hour_out, minute_out, second_out, total_seconds,
		input  is_equal, is_less, is_greater, operand_error,
		output ready
	);
endinterface

/* design/todau_front.sv */
// ----------------------------------------------------------------------------
// todau_front
// two stages: operand check, seconds since midnight, count mod one day
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module todau_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  todau_pkg::todau_req_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output todau_pkg::todau_secs_t out_data
);

	localparam int unsigned DAY_PROD_W =
		(todau_pkg::COUNT_W - todau_pkg::DAY_PRE) + todau_pkg::DAY_RECIP_W;

	logic                              need_a, need_b, err_d;
	logic [todau_pkg::SECS_W-1:0]      ta_d, tb_d;
	logic [DAY_PROD_W-1:0]             day_prod;
	logic [todau_pkg::DAY_Q_W-1:0]     q_d;

	logic                              v_s1, v_s2, rdy_s1, rdy_s2;
	logic [todau_pkg::OP_W-1:0]        op_s1;
	logic                              err_s1;
	logic [todau_pkg::SECS_W-1:0]      ta_s1, tb_s1;
	logic [todau_pkg::COUNT_W-1:0]     cnt_s1;
	logic [todau_pkg::DAY_Q_W-1:0]     q_s1;
	todau_pkg::todau_secs_t            secs_s2;

	// stage 1: checks, conversions, day quotient estimate
	always_comb begin
		need_a = in_data.operation != todau_pkg::OP_FROM_SECONDS;
		need_b = (in_data.operation == todau_pkg::OP_DURATION)
			|| (in_data.operation == todau_pkg::OP_COMPARE);
		err_d = (need_a && !todau_pkg::time_ok(in_data.hour_a, in_data.minute_a,
				in_data.second_a))
			|| (need_b && !todau_pkg::time_ok(in_data.hour_b, in_data.minute_b,
				in_data.second_b));
		ta_d = todau_pkg::to_secs(in_data.hour_a, in_data.minute_a, in_data.second_a);
		tb_d = todau_pkg::to_secs(in_data.hour_b, in_data.minute_b, in_data.second_b);
		day_prod = DAY_PROD_W'(in_data.count_seconds[todau_pkg::COUNT_W-1:todau_pkg::DAY_PRE])
			* DAY_PROD_W'(todau_pkg::DAY_RECIP);
		q_d = day_prod[todau_pkg::DAY_SHIFT +: todau_pkg::DAY_Q_W];
	end

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			op_s1  <= in_data.operation;
			err_s1 <= err_d;
			ta_s1  <= ta_d;
			tb_s1  <= tb_d;
			cnt_s1 <= in_data.count_seconds;
			q_s1   <= q_d;
		end
		// stage 2: remainder of the count
		if (rdy_s2 && v_s1) begin
			secs_s2.operation <= op_s1;
			secs_s2.err       <= err_s1;
			secs_s2.ta        <= ta_s1;
			secs_s2.tb        <= tb_s1;
			secs_s2.cnt_mod   <= todau_pkg::SECS_W'(cnt_s1
				- todau_pkg::COUNT_W'(q_s1) * todau_pkg::COUNT_W'(todau_pkg::SECS_PER_DAY));
		end
	end

	assign out_valid = v_s2;
	assign out_data  = secs_s2;

endmodule

/* design/todau_combine.sv */
// ----------------------------------------------------------------------------
// todau_combine
// one stage: per-operation sum mod one day, duration and compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module todau_combine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  todau_pkg::todau_secs_t in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output todau_pkg::todau_mid_t  out_data
);

	localparam int unsigned SUM_W = todau_pkg::SECS_W + 1;

	logic [SUM_W-1:0]       t_raw, t_red;
	todau_pkg::todau_mid_t  mid_d;
	todau_pkg::todau_mid_t  mid_s3;
	logic                   v_s3, rdy_s3;

	always_comb begin
		t_raw = '0;
		mid_d = '0;
		case (in_data.operation)
			todau_pkg::OP_FROM_SECONDS: t_raw = SUM_W'(in_data.cnt_mod);
			todau_pkg::OP_TO_SECONDS:   mid_d.side.total = in_data.ta;
			todau_pkg::OP_NEXT:         t_raw = SUM_W'(in_data.ta) + SUM_W'(1);
			todau_pkg::OP_PREV: begin
				t_raw = SUM_W'(in_data.ta) + SUM_W'(todau_pkg::SECS_PER_DAY - 1);
			end
			todau_pkg::OP_ADD: t_raw = SUM_W'(in_data.ta) + SUM_W'(in_data.cnt_mod);
			todau_pkg::OP_SUBTRACT: begin
				t_raw = SUM_W'(in_data.ta) + SUM_W'(todau_pkg::SECS_PER_DAY)
					- SUM_W'(in_data.cnt_mod);
			end
			todau_pkg::OP_DURATION: begin
				// b earlier than a lies on the next day
				if (in_data.tb >= in_data.ta)
					mid_d.side.total = in_data.tb - in_data.ta;
				else
					mid_d.side.total = todau_pkg::SECS_W'(SUM_W'(in_data.tb)
						+ SUM_W'(todau_pkg::SECS_PER_DAY) - SUM_W'(in_data.ta));
			end
			todau_pkg::OP_COMPARE: begin
				mid_d.side.eq = in_data.ta == in_data.tb;
				mid_d.side.lt = in_data.ta < in_data.tb;
				mid_d.side.gt = in_data.ta > in_data.tb;
			end
			default: ;
		endcase
		t_red = (t_raw >= SUM_W'(todau_pkg::SECS_PER_DAY))
			? t_raw - SUM_W'(todau_pkg::SECS_PER_DAY) : t_raw;
		mid_d.t = todau_pkg::SECS_W'(t_red);
		// bad operand: everything zero but the flag
		if (in_data.err) begin
			mid_d          = '0;
			mid_d.side.err = 1'b1;
		end
	end

	assign rdy_s3   = !v_s3 || out_ready;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (rdy_s3) v_s3 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) mid_s3 <= mid_d;
	end

	assign out_valid = v_s3;
	assign out_data  = mid_s3;

endmodule

/* design/todau_split.sv */
// ----------------------------------------------------------------------------
// todau_split
// four stages: seconds of day split into hour, minute and second
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module todau_split (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  todau_pkg::todau_mid_t in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output todau_pkg::todau_res_t out_data
);

	localparam int unsigned HOUR_PROD_W =
		(todau_pkg::SECS_W - todau_pkg::HOUR_PRE) + todau_pkg::HOUR_RECIP_W;
	localparam int unsigned MIN_PROD_W =
		(todau_pkg::REM_W - todau_pkg::MIN_PRE) + todau_pkg::MIN_RECIP_W;

	logic [HOUR_PROD_W-1:0]           hour_prod;
	logic [MIN_PROD_W-1:0]            min_prod;

	logic                             v_s4, v_s5, v_s6, v_s7;
	logic                             rdy_s4, rdy_s5, rdy_s6, rdy_s7;
	logic [todau_pkg::HOUR_W-1:0]     hour_s4, hour_s5, hour_s6;
	logic [todau_pkg::SECS_W-1:0]     t_s4;
	logic [todau_pkg::REM_W-1:0]      rem_s5, rem_s6;
	logic [todau_pkg::MINSEC_W-1:0]   minute_s6;
	todau_pkg::todau_side_t           side_s4, side_s5, side_s6;
	todau_pkg::todau_res_t            res_s7;

	assign hour_prod = HOUR_PROD_W'(in_data.t[todau_pkg::SECS_W-1:todau_pkg::HOUR_PRE])
		* HOUR_PROD_W'(todau_pkg::HOUR_RECIP);
	assign min_prod = MIN_PROD_W'(rem_s5[todau_pkg::REM_W-1:todau_pkg::MIN_PRE])
		* MIN_PROD_W'(todau_pkg::MIN_RECIP);

	assign rdy_s7   = !v_s7 || out_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= in_valid;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		// hour by reciprocal
		if (rdy_s4 && in_valid) begin
			hour_s4 <= hour_prod[todau_pkg::HOUR_SHIFT +: todau_pkg::HOUR_W];
			t_s4    <= in_data.t;
			side_s4 <= in_data.side;
		end
		// seconds within the hour
		if (rdy_s5 && v_s4) begin
			hour_s5 <= hour_s4;
			rem_s5  <= todau_pkg::REM_W'(t_s4
				- todau_pkg::SECS_W'(hour_s4) * todau_pkg::SECS_W'(todau_pkg::SECS_PER_HOUR));
			side_s5 <= side_s4;
		end
		// minute by reciprocal
		if (rdy_s6 && v_s5) begin
			hour_s6   <= hour_s5;
			rem_s6    <= rem_s5;
			minute_s6 <= min_prod[todau_pkg::MIN_SHIFT +: todau_pkg::MINSEC_W];
			side_s6   <= side_s5;
		end
		// second and output register
		if (rdy_s7 && v_s6) begin
			res_s7.hour   <= hour_s6;
			res_s7.minute <= minute_s6;
			res_s7.second <= todau_pkg::MINSEC_W'(rem_s6
				- todau_pkg::REM_W'(minute_s6) * todau_pkg::REM_W'(todau_pkg::SECS_PER_MIN));
			res_s7.side   <= side_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_data  = res_s7;

endmodule

/* design/time_of_day_arithmetic_unit.sv */
// throughput: one item per cycle while rsp does not stall, set by the seven-stage pipeline
// each stage takes a new item when it is empty or its successor moves on
// reset: arst_n clears only the stage valid bits, no result is pending after it
// ----------------------------------------------------------------------------
// time_of_day_arithmetic_unit
// pipelined 24-hour time arithmetic: conversion, step, add, subtract,
// duration and compare on hour, minute and second fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "time_of_day_arithmetic_unit_macros.svh"

module time_of_day_arithmetic_unit (
	input  logic         clk,
	input  logic         arst_n,
	todau_in_if.sink     req,
	todau_out_if.source  rsp
);

	// request payload gathered into one word
	todau_pkg::todau_req_t  req_data;

	// front -> combine: seconds since midnight and count mod one day
	logic                   secs_valid, secs_ready;
	todau_pkg::todau_secs_t secs_data;

	// combine -> split: reduced time of day plus non-time results
	logic                   mid_valid, mid_ready;
	todau_pkg::todau_mid_t  mid_data;

	// split -> result channel
	todau_pkg::todau_res_t  res_data;

	assign req_data.operation     = req.operation;
	assign req_data.hour_a        = req.hour_a;
	assign req_data.minute_a      = req.minute_a;
	assign req_data.second_a      = req.second_a;
	assign req_data.hour_b        = req.hour_b;
	assign req_data.minute_b      = req.minute_b;
	assign req_data.second_b      = req.second_b;
	assign req_data.count_seconds = req.count_seconds;

	// stages 1-2: operand range check, time to seconds, count mod 86400
	todau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_data   (req_data),
		.out_valid (secs_valid),
		.out_ready (secs_ready),
		.out_data  (secs_data)
	);

	// stage 3: per-operation sum with one wrap, duration, compare flags,
	// and zeroing of every field but the error flag on an operand error
	todau_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (secs_valid),
		.in_ready  (secs_ready),
		.in_data   (secs_data),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	// stages 4-7: hour, remainder, minute, second; stage 7 is the output register
	todau_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (res_data)
	);

	assign rsp.hour_out      = res_data.hour;
	assign rsp.minute_out    = res_data.minute;
	assign rsp.second_out    = res_data.second;
	assign rsp.total_seconds = res_data.side.total;
	assign rsp.is_equal      = res_data.side.eq;
	assign rsp.is_less       = res_data.side.lt;
	assign rsp.is_greater    = res_data.side.gt;
	assign rsp.operand_error = res_data.side.err;

	// an error result carries nothing but the flag
	`TODAU_ASSERT_IMPLY(a_err_zero, clk, arst_n, (rsp.valid && rsp.operand_error), ((rsp.hour_out == '0) && (rsp.minute_out == '0) && (rsp.second_out == '0) && (rsp.total_seconds == '0) && !rsp.is_equal && !rsp.is_less && !rsp.is_greater), "error result has nonzero fields")

	// the split always lands in range and at most one compare flag is up
	`TODAU_ASSERT_IMPLY(a_out_range, clk, arst_n, rsp.valid, ((rsp.hour_out <= 5'd23) && (rsp.minute_out <= 6'd59) && (rsp.second_out <= 6'd59) && (rsp.total_seconds < 17'd86400) && $onehot0({rsp.is_equal, rsp.is_less, rsp.is_greater})), "result field out of range")

	// a compare result has no time and no count
	`TODAU_ASSERT_IMPLY(a_cmp_clean, clk, arst_n, (rsp.valid && (rsp.is_equal || rsp.is_less || rsp.is_greater)), ((rsp.hour_out == '0) && (rsp.minute_out == '0) && (rsp.second_out == '0) && (rsp.total_seconds == '0)), "compare result carries a time")

	// a stalled item between combine and split stays put
	`TODAU_ASSERT_NEXT(a_mid_hold, clk, arst_n, (mid_valid && !mid_ready), (mid_valid && $stable(mid_data)), "stalled mid-pipe item changed")

endmodule

/* dv/time_of_day_arithmetic_unit_tb.sv */
// ----------------------------------------------------------------------------
// time_of_day_arithmetic_unit_tb
// drives hh:mm:ss arithmetic requests through the pipelined time unit and
// checks every result against an in-order prediction; the sender works in
// bursts and the receiver stalls on its own pattern
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_of_day_arithmetic_unit_tb;

	localparam int unsigned RESET_CYCLES     = 11;
	localparam int unsigned RANDOM_FIRST     = 975;
	localparam int unsigned RANDOM_SECOND    = 950;
	localparam int unsigned LONG_HOLD_START  = 1200;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES    = 16;
	localparam int unsigned WATCHDOG_LIMIT   = 4000;

	typedef struct packed {
		logic [todau_pkg::HOUR_W-1:0]   hour;
		logic [todau_pkg::MINSEC_W-1:0] minute;
		logic [todau_pkg::MINSEC_W-1:0] second;
		logic [todau_pkg::SECS_W-1:0]   total;
		logic                           eq;
		logic                           lt;
		logic                           gt;
		logic                           err;
	} tod_result_t;

	typedef struct packed {
		logic [todau_pkg::HOUR_W-1:0]   hour;
		logic [todau_pkg::MINSEC_W-1:0] minute;
		logic [todau_pkg::MINSEC_W-1:0] second;
	} tod_clock_t;

	// in-order store of predicted results with field-by-field checking
	class tod_scoreboard;
		tod_result_t expected_results[$];
		int unsigned results_checked;
		int unsigned error_results;
		int unsigned mismatch_count;

		function tod_result_t compute_time_result(todau_pkg::todau_req_t r);
			tod_result_t res;
			logic a_used, b_used, a_ok, b_ok, has_time;
			int unsigned secs_a, secs_b, cnt, t;
			res = '0;
			has_time = 1'b0;
			t = 0;
			cnt = r.count_seconds % todau_pkg::SECS_PER_DAY;
			a_used = r.operation != todau_pkg::OP_FROM_SECONDS;
			b_used = r.operation == todau_pkg::OP_DURATION
				|| r.operation == todau_pkg::OP_COMPARE;
			a_ok = r.hour_a <= todau_pkg::MAX_HOUR && r.minute_a <= todau_pkg::MAX_MINSEC
				&& r.second_a <= todau_pkg::MAX_MINSEC;
			b_ok = r.hour_b <= todau_pkg::MAX_HOUR && r.minute_b <= todau_pkg::MAX_MINSEC
				&& r.second_b <= todau_pkg::MAX_MINSEC;
			// a bad time in a used operand zeroes everything but the flag
			if ((a_used && !a_ok) || (b_used && !b_ok)) begin
				res.err = 1'b1;
				return res;
			end
			secs_a = r.hour_a * todau_pkg::SECS_PER_HOUR
				+ r.minute_a * todau_pkg::SECS_PER_MIN + r.second_a;
			secs_b = r.hour_b * todau_pkg::SECS_PER_HOUR
				+ r.minute_b * todau_pkg::SECS_PER_MIN + r.second_b;
			case (r.operation)
				todau_pkg::OP_FROM_SECONDS: begin
					t = cnt;
					has_time = 1'b1;
				end
				todau_pkg::OP_TO_SECONDS: res.total = todau_pkg::SECS_W'(secs_a);
				todau_pkg::OP_NEXT: begin
					t = secs_a + 1;
					has_time = 1'b1;
				end
				todau_pkg::OP_PREV: begin
					t = secs_a + todau_pkg::SECS_PER_DAY - 1;
					has_time = 1'b1;
				end
				todau_pkg::OP_ADD: begin
					t = secs_a + cnt;
					has_time = 1'b1;
				end
				todau_pkg::OP_SUBTRACT: begin
					t = secs_a + todau_pkg::SECS_PER_DAY - cnt;
					has_time = 1'b1;
				end
				todau_pkg::OP_DURATION: begin
					res.total = todau_pkg::SECS_W'((secs_b + todau_pkg::SECS_PER_DAY - secs_a)
						% todau_pkg::SECS_PER_DAY);
				end
				todau_pkg::OP_COMPARE: begin
					res.eq = secs_a == secs_b;
					res.lt = secs_a < secs_b;
					res.gt = secs_a > secs_b;
				end
				default: ;
			endcase
			if (has_time) begin
				t = t % todau_pkg::SECS_PER_DAY;
				res.hour = todau_pkg::HOUR_W'(t / todau_pkg::SECS_PER_HOUR);
				res.minute = todau_pkg::MINSEC_W'((t % todau_pkg::SECS_PER_HOUR)
					/ todau_pkg::SECS_PER_MIN);
				res.second = todau_pkg::MINSEC_W'(t % todau_pkg::SECS_PER_MIN);
			end
			return res;
		endfunction

		function void note_request(todau_pkg::todau_req_t r);
			expected_results.push_back(compute_time_result(r));
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatch_count++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0h expected %0h",
					results_checked, name, got, want));
		endtask

		task check_result(tod_result_t got);
			tod_result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result after %0d checked with no item waiting",
					results_checked));
				return;
			end
			want = expected_results.pop_front();
			compare_field("hour_out", 32'(got.hour), 32'(want.hour));
			compare_field("minute_out", 32'(got.minute), 32'(want.minute));
			compare_field("second_out", 32'(got.second), 32'(want.second));
			compare_field("total_seconds", 32'(got.total), 32'(want.total));
			compare_field("is_equal", 32'(got.eq), 32'(want.eq));
			compare_field("is_less", 32'(got.lt), 32'(want.lt));
			compare_field("is_greater", 32'(got.gt), 32'(want.gt));
			compare_field("operand_error", 32'(got.err), 32'(want.err));
			if (want.err)
				error_results++;
			results_checked++;
		endtask

		task final_check();
			if (expected_results.size() != 0)
				report($sformatf("%0d results never arrived", expected_results.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned items_sent = 0;
	tod_scoreboard board;

	todau_in_if  req_if ();
	todau_out_if rsp_if ();

	time_of_day_arithmetic_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial begin : clock_gen
		forever #2 clk = ~clk;
	end

	// mostly legal clocks, biased to the edges; now and then any bit pattern
	function automatic tod_clock_t pick_clock();
		tod_clock_t c;
		if ($urandom_range(0, 7) == 0) begin
			c.hour = todau_pkg::HOUR_W'($urandom_range(0, 31));
			c.minute = todau_pkg::MINSEC_W'($urandom_range(0, 63));
			c.second = todau_pkg::MINSEC_W'($urandom_range(0, 63));
		end else begin
			c.hour = ($urandom_range(0, 5) == 0)
				? todau_pkg::HOUR_W'(todau_pkg::MAX_HOUR * $urandom_range(0, 1))
				: todau_pkg::HOUR_W'($urandom_range(0, todau_pkg::MAX_HOUR));
			c.minute = ($urandom_range(0, 5) == 0)
				? todau_pkg::MINSEC_W'(todau_pkg::MAX_MINSEC * $urandom_range(0, 1))
				: todau_pkg::MINSEC_W'($urandom_range(0, todau_pkg::MAX_MINSEC));
			c.second = ($urandom_range(0, 5) == 0)
				? todau_pkg::MINSEC_W'(todau_pkg::MAX_MINSEC * $urandom_range(0, 1))
				: todau_pkg::MINSEC_W'($urandom_range(0, todau_pkg::MAX_MINSEC));
		end
		return c;
	endfunction

	function automatic todau_pkg::todau_req_t random_request();
		todau_pkg::todau_req_t r;
		tod_clock_t ca, cb;
		ca = pick_clock();
		cb = pick_clock();
		r.operation = todau_pkg::OP_W'($urandom_range(0, 7));
		// equal times are rare by chance, so force some for duration and compare
		if ((r.operation == todau_pkg::OP_DURATION || r.operation == todau_pkg::OP_COMPARE)
				&& $urandom_range(0, 3) == 0)
			cb = ca;
		{r.hour_a, r.minute_a, r.second_a} = ca;
		{r.hour_b, r.minute_b, r.second_b} = cb;
		case ($urandom_range(0, 3))
			0: r.count_seconds = $urandom;
			1: r.count_seconds = $urandom_range(0, todau_pkg::SECS_PER_DAY - 1);
			2: r.count_seconds = $urandom_range(1, 49710) * todau_pkg::SECS_PER_DAY
				+ $urandom_range(0, 2);
			default: r.count_seconds = $urandom_range(0, 200);
		endcase
		return r;
	endfunction

	function automatic todau_pkg::todau_req_t make_request(
			logic [todau_pkg::OP_W-1:0] op,
			int unsigned ha, int unsigned ma, int unsigned sa,
			int unsigned hb, int unsigned mb, int unsigned sec_b,
			logic [todau_pkg::COUNT_W-1:0] cnt);
		todau_pkg::todau_req_t r;
		r.operation = op;
		r.hour_a = todau_pkg::HOUR_W'(ha);
		r.minute_a = todau_pkg::MINSEC_W'(ma);
		r.second_a = todau_pkg::MINSEC_W'(sa);
		r.hour_b = todau_pkg::HOUR_W'(hb);
		r.minute_b = todau_pkg::MINSEC_W'(mb);
		r.second_b = todau_pkg::MINSEC_W'(sec_b);
		r.count_seconds = cnt;
		return r;
	endfunction

	task automatic drive_fields(input todau_pkg::todau_req_t r);
		req_if.operation <= r.operation;
		req_if.hour_a <= r.hour_a;
		req_if.minute_a <= r.minute_a;
		req_if.second_a <= r.second_a;
		req_if.hour_b <= r.hour_b;
		req_if.minute_b <= r.minute_b;
		req_if.second_b <= r.second_b;
		req_if.count_seconds <= r.count_seconds;
	endtask

	// bursts of random length; during a gap the payload carries junk
	task automatic send_items(input todau_pkg::todau_req_t items[$]);
		int unsigned burst_left, gap, i;
		burst_left = $urandom_range(1, 48);
		for (i = 0; i < items.size(); i++) begin
			req_if.valid <= 1'b1;
			drive_fields(items[i]);
			do @(posedge clk); while (!req_if.ready);
			items_sent++;
			burst_left = burst_left - 1;
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					req_if.valid <= 1'b0;
					drive_fields(random_request());
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 48);
			end
		end
		req_if.valid <= 1'b0;
	endtask

	// counters move at the rising edge, so look at them on the falling one
	task automatic wait_for_drain();
		do @(negedge clk); while (board.pending() != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		todau_pkg::todau_req_t directed_q[$];
		todau_pkg::todau_req_t random_q[$];
		int unsigned n;
		board = new();
		req_if.valid <= 1'b0;
		drive_fields('0);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// edges of the day, ripple carries and borrows, bad and unused operands
		directed_q.push_back(make_request(todau_pkg::OP_FROM_SECONDS,
			31, 63, 63, 31, 63, 63, 0));
		directed_q.push_back(make_request(todau_pkg::OP_FROM_SECONDS,
			0, 0, 0, 0, 0, 0, 86399));
		directed_q.push_back(make_request(todau_pkg::OP_FROM_SECONDS,
			0, 0, 0, 0, 0, 0, 86400));
		directed_q.push_back(make_request(todau_pkg::OP_FROM_SECONDS,
			24, 60, 60, 0, 0, 0, 32'hffff_ffff));
		directed_q.push_back(make_request(todau_pkg::OP_TO_SECONDS,
			23, 59, 59, 31, 63, 63, 0));
		directed_q.push_back(make_request(todau_pkg::OP_TO_SECONDS,
			0, 0, 0, 0, 0, 0, 32'hffff_ffff));
		directed_q.push_back(make_request(todau_pkg::OP_NEXT, 23, 59, 59, 0, 0, 0, 0));
		directed_q.push_back(make_request(todau_pkg::OP_NEXT, 12, 34, 59, 0, 0, 0, 0));
		directed_q.push_back(make_request(todau_pkg::OP_PREV, 0, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(make_request(todau_pkg::OP_PREV, 10, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(make_request(todau_pkg::OP_ADD, 23, 59, 59, 31, 63, 63, 1));
		directed_q.push_back(make_request(todau_pkg::OP_ADD,
			0, 0, 0, 0, 0, 0, 32'hffff_ffff));
		directed_q.push_back(make_request(todau_pkg::OP_SUBTRACT, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_request(todau_pkg::OP_SUBTRACT,
			12, 0, 0, 0, 0, 0, 86400));
		directed_q.push_back(make_request(todau_pkg::OP_DURATION,
			7, 30, 15, 7, 30, 15, 0));
		directed_q.push_back(make_request(todau_pkg::OP_DURATION, 22, 0, 0, 1, 0, 0, 0));
		directed_q.push_back(make_request(todau_pkg::OP_DURATION,
			0, 0, 0, 23, 59, 59, 0));
		directed_q.push_back(make_request(todau_pkg::OP_COMPARE,
			23, 59, 59, 23, 59, 59, 0));
		directed_q.push_back(make_request(todau_pkg::OP_COMPARE, 0, 0, 0, 0, 0, 1, 0));
		directed_q.push_back(make_request(todau_pkg::OP_COMPARE,
			23, 59, 59, 0, 0, 0, 0));
		directed_q.push_back(make_request(todau_pkg::OP_TO_SECONDS, 24, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(make_request(todau_pkg::OP_NEXT, 5, 60, 0, 0, 0, 0, 0));
		directed_q.push_back(make_request(todau_pkg::OP_ADD, 31, 0, 63, 0, 0, 0, 5));
		directed_q.push_back(make_request(todau_pkg::OP_DURATION, 1, 2, 3, 4, 63, 5, 0));
		directed_q.push_back(make_request(todau_pkg::OP_COMPARE, 1, 2, 3, 31, 5, 6, 0));
		send_items(directed_q);

		// sender holds off until the pipeline is empty, then random traffic
		wait_for_drain();
		for (n = 0; n < RANDOM_FIRST; n++)
			random_q.push_back(random_request());
		send_items(random_q);
		wait_for_drain();
		random_q.delete();
		for (n = 0; n < RANDOM_SECOND; n++)
			random_q.push_back(random_request());
		send_items(random_q);

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		board.final_check();
		$display("summary: %0d items driven over all eight operations, %0d results checked",
			items_sent, board.results_checked);
		$display("summary: %0d results carried an invalid time flag, %0d mismatches",
			board.error_results, board.mismatch_count);
		if (board.mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// receiver: segments of free flow, light and heavy stalls and square waves,
	// plus one long hold-off so the pipeline backs up into the sender
	initial begin : receiver
		int unsigned style, span, period, k, elapsed;
		bit held_off;
		rsp_if.ready <= 1'b0;
		held_off = 1'b0;
		elapsed = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && elapsed >= LONG_HOLD_START) begin
				held_off = 1'b1;
				for (k = 0; k < LONG_HOLD_CYCLES; k++) begin
					rsp_if.ready <= 1'b0;
					@(posedge clk);
				end
			end
			style = $urandom_range(0, 3);
			span = $urandom_range(10, 150);
			period = $urandom_range(2, 7);
			for (k = 0; k < span; k++) begin
				case (style)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_if.ready <= ((k % period) < (period / 2));
				endcase
				@(posedge clk);
			end
			elapsed += span;
		end
	end

	// result check before the new item is noted, both at the same edge
	always @(posedge clk) begin : monitor
		tod_result_t seen;
		todau_pkg::todau_req_t taken;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				seen.hour = rsp_if.hour_out;
				seen.minute = rsp_if.minute_out;
				seen.second = rsp_if.second_out;
				seen.total = rsp_if.total_seconds;
				seen.eq = rsp_if.is_equal;
				seen.lt = rsp_if.is_less;
				seen.gt = rsp_if.is_greater;
				seen.err = rsp_if.operand_error;
				board.check_result(seen);
			end
			if (req_if.valid && req_if.ready) begin
				taken.operation = req_if.operation;
				taken.hour_a = req_if.hour_a;
				taken.minute_a = req_if.minute_a;
				taken.second_a = req_if.second_a;
				taken.hour_b = req_if.hour_b;
				taken.minute_b = req_if.minute_b;
				taken.second_b = req_if.second_b;
				taken.count_seconds = req_if.count_seconds;
				board.note_request(taken);
			end
		end
	end

	// ends the run when neither channel has moved for too long
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule

/* time_of_day_arithmetic_unit.f */
+incdir+design
design/todau_pkg.sv
design/todau_in_if.sv
design/todau_out_if.sv
design/todau_front.sv
design/todau_combine.sv
design/todau_split.sv
design/time_of_day_arithmetic_unit.sv
dv/time_of_day_arithmetic_unit_tb.sv
